// ===== rtl/nfa_pkg.sv =====
// ----------------------------------------------------------------------------
// nfa_pkg
// Shared types and constants of the next-fit ID allocator.
// ----------------------------------------------------------------------------
package nfa_pkg;

  // id and count width, fixed by the transaction fields
  localparam int unsigned IDW          = 10;
  // width of one map word and of the bit select inside it
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned WSEL_W       = 5;
  // width of the map word index taken from an id
  localparam int unsigned WIX_W        = IDW - WSEL_W;
  // default number of id slots, including the reserved id 0
  localparam int unsigned DEF_ID_SLOTS = 1024;
  // capacity register after reset
  localparam logic [IDW-1:0] CAP_RESET = 10'd1023;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADREL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE
  } state_e;

  typedef struct packed {
    kind_e          kind;
    logic [IDW-1:0] release_id;
  } req_t;

  typedef struct packed {
    logic [IDW-1:0] granted_id;
    status_e        status;
    logic [IDW-1:0] in_use;
  } rsp_t;

endpackage

// ===== rtl/nfa_ram.sv =====
// ----------------------------------------------------------------------------
// nfa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module nfa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/next_fit_id_allocator.sv =====
// ----------------------------------------------------------------------------
// next_fit_id_allocator
// Next-fit allocator of IDs 1..capacity over a used bitmap held in a RAM.
// ----------------------------------------------------------------------------
// Usage:
//   A request transaction (req_i) is taken when start_i is high and busy_o is
//   low. An allocate scans the used map forward from the cursor, one 32-bit
//   RAM word per cycle with a priority encoder, wrapping from capacity to 1.
//   A free reads the word of release_id, checks and clears its bit.
//   Each request gives one result on rsp_o, marked by done_o for one cycle.
//   The receiver cannot stall; a new request may start in the cycle that
//   shows the previous result.
//   A full map (count at capacity) or an invalid id is answered from idle
//   without a map read; a free reads the word of release_id, then checks
//   and writes it; an allocate visits one word after another until a free
//   bit is found or the lap is back at the start word.
//   The capacity register is written on the cfg channel (always ready).
//   After reset the map RAM is cleared one word per cycle, all ID_SLOTS/32
//   words (rounded up), with busy_o high; cursor goes to 1, count to 0.
// ----------------------------------------------------------------------------
module next_fit_id_allocator
  import nfa_pkg::*;
#(
  parameter int unsigned ID_SLOTS = DEF_ID_SLOTS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  req_t           req_i,
  output logic           done_o,
  output rsp_t           rsp_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [IDW-1:0] cfg_data_i
);

  localparam int unsigned WORDS = (ID_SLOTS + WORD_W - 1) / WORD_W;
  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned CAP_MAX_I = (ID_SLOTS - 1 > 1023) ? 1023 : ID_SLOTS - 1;
  localparam logic [IDW-1:0] CAP_MAX = IDW'(CAP_MAX_I);

  // map word index to ram address
  function automatic logic [AW-1:0] word_addr(input logic [WIX_W-1:0] w);
    logic [AW+WIX_W-1:0] ext;
    ext = {{AW{1'b0}}, w};
    return ext[AW-1:0];
  endfunction

  state_e            state_q, state_d;
  logic [IDW-1:0]    capacity_q;
  logic [IDW-1:0]    cursor_q, cursor_d;
  logic [IDW-1:0]    count_q, count_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [IDW-1:0]    start_q, start_d;
  logic [IDW-1:0]    rel_q, rel_d;
  logic [WIX_W-1:0]  scan_w_q, scan_w_d;
  logic              first_q, first_d;
  logic              last_q, last_d;
  logic              done_q, done_d;
  rsp_t              rsp_q, rsp_d;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  logic [IDW-1:0]    cap_eff;
  logic [IDW-1:0]    pos0;
  logic [WIX_W-1:0]  cap_w, next_w;
  logic [WSEL_W-1:0] cap_lo, plo;
  logic [WORD_W-1:0] free_vec;
  logic              hit;
  logic [WSEL_W-1:0] hit_idx;

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      capacity_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // capacity in use and scan start
  assign cap_eff = (capacity_q > CAP_MAX) ? CAP_MAX : capacity_q;
  assign cap_w   = cap_eff[IDW-1:WSEL_W];
  assign cap_lo  = cap_eff[WSEL_W-1:0];
  assign pos0    = (cursor_q == '0 || cursor_q > cap_eff) ? IDW'(1) : cursor_q;
  assign plo     = start_q[WSEL_W-1:0];
  assign next_w  = (scan_w_q == cap_w) ? '0 : scan_w_q + WIX_W'(1);

  // free bits of the word under scan, limited to the lap
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      free_vec[b] = !ram_rdata[b]
                  && (scan_w_q < cap_w || WSEL_W'(b) <= cap_lo)
                  && !(scan_w_q == '0 && b == 0)
                  && (!first_q || WSEL_W'(b) >= plo)
                  && (!last_q || WSEL_W'(b) < plo);
    end
  end

  // lowest free bit
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        hit     = 1'b1;
        hit_idx = WSEL_W'(i);
      end
    end
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      cursor_q <= IDW'(1);
      count_q  <= '0;
      clr_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cursor_q <= cursor_d;
      count_q  <= count_d;
      clr_q    <= clr_d;
      done_q   <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    start_q  <= start_d;
    rel_q    <= rel_d;
    scan_w_q <= scan_w_d;
    first_q  <= first_d;
    last_q   <= last_d;
    rsp_q    <= rsp_d;
  end

  // next state and ram control
  always_comb begin
    state_d   = state_q;
    cursor_d  = cursor_q;
    count_d   = count_q;
    clr_d     = clr_q;
    start_d   = start_q;
    rel_d     = rel_q;
    scan_w_d  = scan_w_q;
    first_d   = first_q;
    last_d    = last_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    ram_we    = 1'b0;
    ram_waddr = word_addr(scan_w_q);
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = word_addr(next_w);
    case (state_q)
      S_CLEAR: begin
        // clear the map one word per cycle
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          rel_d   = req_i.release_id;
          start_d = pos0;
          if (req_i.kind == KIND_ALLOC) begin
            if (count_q >= cap_eff) begin
              // full without a scan
              cursor_d         = pos0;
              done_d           = 1'b1;
              rsp_d.granted_id = '0;
              rsp_d.status     = ST_FULL;
              rsp_d.in_use     = count_q;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = word_addr(pos0[IDW-1:WSEL_W]);
              scan_w_d  = pos0[IDW-1:WSEL_W];
              first_d   = 1'b1;
              last_d    = 1'b0;
              state_d   = S_SCAN;
            end
          end else begin
            if (req_i.release_id == '0 || req_i.release_id > cap_eff) begin
              done_d           = 1'b1;
              rsp_d.granted_id = '0;
              rsp_d.status     = ST_BADREL;
              rsp_d.in_use     = count_q;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = word_addr(req_i.release_id[IDW-1:WSEL_W]);
              state_d   = S_FREE;
            end
          end
        end
      end
      S_SCAN: begin
        // evaluate this word, fetch the next one
        ram_re   = 1'b1;
        scan_w_d = next_w;
        first_d  = 1'b0;
        last_d   = (next_w == start_q[IDW-1:WSEL_W]);
        if (hit) begin
          ram_we           = 1'b1;
          ram_wdata        = ram_rdata | (WORD_W'(1) << hit_idx);
          cursor_d         = {scan_w_q, hit_idx};
          count_d          = count_q + IDW'(1);
          done_d           = 1'b1;
          rsp_d.granted_id = {scan_w_q, hit_idx};
          rsp_d.status     = ST_OK;
          rsp_d.in_use     = count_q + IDW'(1);
          state_d          = S_IDLE;
        end else if (last_q) begin
          cursor_d         = start_q;
          done_d           = 1'b1;
          rsp_d.granted_id = '0;
          rsp_d.status     = ST_FULL;
          rsp_d.in_use     = count_q;
          state_d          = S_IDLE;
        end
      end
      S_FREE: begin
        // check and clear the released bit
        ram_waddr        = word_addr(rel_q[IDW-1:WSEL_W]);
        done_d           = 1'b1;
        rsp_d.granted_id = '0;
        state_d          = S_IDLE;
        if (ram_rdata[rel_q[WSEL_W-1:0]]) begin
          ram_we       = 1'b1;
          ram_wdata    = ram_rdata & ~(WORD_W'(1) << rel_q[WSEL_W-1:0]);
          cursor_d     = rel_q;
          count_d      = (count_q != '0) ? count_q - IDW'(1) : count_q;
          rsp_d.status = ST_OK;
          rsp_d.in_use = (count_q != '0) ? count_q - IDW'(1) : count_q;
        end else begin
          rsp_d.status = ST_BADREL;
          rsp_d.in_use = count_q;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // used map storage
  nfa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef ASSERT_OFF
  // a result is only shown while the block is ready for the next request
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // a failed request never hands out an id
  a_fail_no_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != ST_OK) |-> (rsp_o.granted_id == '0))
    else $error("id granted on failed request");

  // the cursor rests on the id just granted
  a_cursor_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.granted_id != '0) |-> (cursor_q == rsp_o.granted_id))
    else $error("cursor not on granted id");

  // the map is never written while waiting for a request
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q != S_IDLE))
    else $error("map write while idle");
`endif

endmodule
